// File: rtl/ffcr_pkg.sv
// shared types and constants for the face flux to cell reconstruction block
// no dependencies
package ffcr_pkg;

    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_INTERIOR = 2'd1;
    localparam logic [1:0] KIND_BOUNDARY = 2'd2;
    localparam logic [1:0] KIND_READOUT  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam int FLAG_DIVZ_BIT = 0;
    localparam int FLAG_SAT_BIT  = 1;

    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE  = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd2;
    localparam logic [OP_W-1:0] OP_READ     = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_X    = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_Y    = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_Z    = 4'd6;
    localparam logic [OP_W-1:0] OP_SUM      = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_F    = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_FACE = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_READ = 4'd10;
    localparam logic [OP_W-1:0] OP_ACC      = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT      = 4'd12;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd13;
    localparam logic [OP_W-1:0] OP_SIDE     = 4'd14;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         owner_cell;
        logic [9:0]         neighbour_cell;
        logic signed [31:0] area_x;
        logic signed [31:0] area_y;
        logic signed [31:0] area_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] flux;
        logic [30:0]        magnitude;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         cell_index;
        logic signed [31:0] cell_value;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       side;
        logic       cell_ok;
        logic       div_busy;
        logic       out_free;
        logic       clr_last;
    } stat_t;

endpackage

// File: rtl/ffcr_ram.sv
// generic single write port memory with registered read
// no dependencies
module ffcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ffcr_div.sv
// iterative restoring divider, signed 64 bit by unsigned 31 bit, saturating
// uses ffcr_pkg
module ffcr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic [30:0]        den,
    output logic               busy,
    output logic signed [31:0] quot,
    output logic [1:0]         flags
);

    localparam int STEPS = 64;

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [30:0] den_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        nz_reg;
    logic [31:0] rem_sh;
    logic        ge;
    logic [31:0] rem_sub;
    logic [63:0] mag;

    assign mag     = num[63] ? (~num + 64'd1) : num;
    assign rem_sh  = {rem_reg, q_reg[63]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = (den != 31'd0);
            cnt_next  = 7'(STEPS);
            rem_next  = '0;
            q_next    = mag;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[30:0] : rem_sh[30:0];
            q_next    = {q_reg[62:0], ge};
            cnt_next  = cnt_reg - 7'd1;
            busy_next = (cnt_reg != 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg  <= den;
            neg_reg  <= num[63];
            zero_reg <= (den == 31'd0);
            nz_reg   <= (num != 64'd0);
        end
    end

    always_comb
    begin
        flags = 2'b00;
        quot  = '0;
        if (zero_reg)
        begin
            flags[ffcr_pkg::FLAG_DIVZ_BIT] = 1'b1;
            if (nz_reg)
            begin
                quot = neg_reg ? ffcr_pkg::S32_MIN : ffcr_pkg::S32_MAX;
            end
        end
        else if (neg_reg)
        begin
            if (q_reg > 64'h8000_0000)
            begin
                flags[ffcr_pkg::FLAG_SAT_BIT] = 1'b1;
                quot = ffcr_pkg::S32_MIN;
            end
            else
            begin
                quot = ~q_reg[31:0] + 32'd1;
            end
        end
        else
        begin
            if (q_reg > 64'h7fff_ffff)
            begin
                flags[ffcr_pkg::FLAG_SAT_BIT] = 1'b1;
                quot = ffcr_pkg::S32_MAX;
            end
            else
            begin
                quot = q_reg[31:0];
            end
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/ffcr_datapath.sv
// datapath: cell stores, shared multiplier, dot product, accumulator update, output register
// uses ffcr_pkg, ffcr_ram, ffcr_div
module ffcr_datapath #(
    parameter int CELL_COUNT    = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffcr_pkg::cmd_t       cmd,
    input  ffcr_pkg::in_item_t   item,
    output ffcr_pkg::stat_t      stat,
    output ffcr_pkg::out_item_t  result,
    output logic                 result_valid,
    input  logic                 result_stall
);

    localparam int AW = $clog2(CELL_COUNT > 1 ? CELL_COUNT : 2);

    ffcr_pkg::in_item_t  item_reg;
    ffcr_pkg::out_item_t result_reg;
    logic                result_valid_reg;
    logic                side_reg;
    logic [AW-1:0]       clr_reg;
    logic signed [65:0]  prod_reg;
    logic signed [50:0]  dot_reg;
    logic [1:0]          flag_reg;

    logic [9:0]          cell_sel;
    logic [31:0]         cell_wide;
    logic [AW-1:0]       addr;
    logic                cell_ok;
    logic                rd_en;

    logic [31:0]         cx, cy, cz;
    logic [30:0]         vol;
    logic [33:0]         acc_dout;
    logic                acc_we;
    logic [AW-1:0]       acc_waddr;
    logic [33:0]         acc_wdata;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  product;
    logic signed [50:0]  prod_term;
    logic                dot_sat;
    logic [31:0]         dot_clamp;

    logic                div_start;
    logic signed [63:0]  div_num;
    logic [30:0]         div_den;
    logic                div_busy;
    logic signed [31:0]  div_quot;
    logic [1:0]          div_flags;
    logic signed [63:0]  acc64;

    logic signed [32:0]  sum33;
    logic                acc_sat;
    logic [31:0]         new_acc;
    logic [1:0]          new_flags;
    logic [1:0]          rd_flags;

    assign cell_sel  = side_reg ? item_reg.neighbour_cell : item_reg.owner_cell;
    assign cell_wide = 32'(cell_sel);
    assign addr      = cell_wide[AW-1:0];
    assign cell_ok   = cell_wide < 32'(CELL_COUNT);
    assign rd_en     = (cmd.op == ffcr_pkg::OP_READ);

    ffcr_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_cx (
        .clk(clk), .we((cmd.op == ffcr_pkg::OP_LOAD) && cell_ok), .waddr(addr),
        .wdata(item_reg.point_x), .re(rd_en), .raddr(addr), .rdata(cx)
    );
    ffcr_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_cy (
        .clk(clk), .we((cmd.op == ffcr_pkg::OP_LOAD) && cell_ok), .waddr(addr),
        .wdata(item_reg.point_y), .re(rd_en), .raddr(addr), .rdata(cy)
    );
    ffcr_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_cz (
        .clk(clk), .we((cmd.op == ffcr_pkg::OP_LOAD) && cell_ok), .waddr(addr),
        .wdata(item_reg.point_z), .re(rd_en), .raddr(addr), .rdata(cz)
    );
    ffcr_ram #(.WIDTH(31), .DEPTH(CELL_COUNT)) u_vol (
        .clk(clk), .we((cmd.op == ffcr_pkg::OP_LOAD) && cell_ok), .waddr(addr),
        .wdata(item_reg.magnitude), .re(rd_en), .raddr(addr), .rdata(vol)
    );
    ffcr_ram #(.WIDTH(34), .DEPTH(CELL_COUNT)) u_acc (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .re(rd_en), .raddr(addr), .rdata(acc_dout)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ffcr_pkg::OP_MUL_X:
            begin
                mul_a = {item_reg.area_x[31], item_reg.area_x};
                mul_b = {item_reg.point_x[31], item_reg.point_x} - {cx[31], cx};
            end
            ffcr_pkg::OP_MUL_Y:
            begin
                mul_a = {item_reg.area_y[31], item_reg.area_y};
                mul_b = {item_reg.point_y[31], item_reg.point_y} - {cy[31], cy};
            end
            ffcr_pkg::OP_MUL_Z:
            begin
                mul_a = {item_reg.area_z[31], item_reg.area_z};
                mul_b = {item_reg.point_z[31], item_reg.point_z} - {cz[31], cz};
            end
            ffcr_pkg::OP_MUL_F:
            begin
                mul_a = {dot_clamp[31], dot_clamp};
                mul_b = {item_reg.flux[31], item_reg.flux};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product   = mul_a * mul_b;
    assign prod_term = 51'(prod_reg >>> FRACTION_BITS);

    assign dot_sat   = (dot_reg[50:31] != {20{dot_reg[31]}});
    assign dot_clamp = dot_sat ? (dot_reg[50] ? ffcr_pkg::S32_MIN : ffcr_pkg::S32_MAX)
                               : dot_reg[31:0];

    // divider operands
    assign acc64     = {{32{acc_dout[31]}}, acc_dout[31:0]};
    assign div_start = (cmd.op == ffcr_pkg::OP_DIV_FACE) || (cmd.op == ffcr_pkg::OP_DIV_READ);
    assign div_num   = (cmd.op == ffcr_pkg::OP_DIV_READ) ? (acc64 <<< FRACTION_BITS)
                                                         : prod_reg[63:0];
    assign div_den   = (cmd.op == ffcr_pkg::OP_DIV_READ) ? vol : item_reg.magnitude;

    ffcr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .busy(div_busy), .quot(div_quot), .flags(div_flags)
    );

    // saturating accumulator update
    assign sum33     = side_reg ? ({acc_dout[31], acc_dout[31:0]} - {div_quot[31], div_quot})
                                : ({acc_dout[31], acc_dout[31:0]} + {div_quot[31], div_quot});
    assign acc_sat   = (sum33[32] != sum33[31]);
    assign new_acc   = acc_sat ? (sum33[32] ? ffcr_pkg::S32_MIN : ffcr_pkg::S32_MAX)
                               : sum33[31:0];
    assign new_flags = acc_dout[33:32] | flag_reg | div_flags | {acc_sat, 1'b0};
    assign rd_flags  = acc_dout[33:32] | div_flags;

    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = addr;
        acc_wdata = '0;
        case (cmd.op)
            ffcr_pkg::OP_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
            end
            ffcr_pkg::OP_ACC:
            begin
                acc_we    = cell_ok;
                acc_wdata = {new_flags, new_acc};
            end
            ffcr_pkg::OP_OUT:
            begin
                acc_we    = cell_ok;
            end
            default:
            begin
                acc_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            clr_reg          <= '0;
            side_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.op == ffcr_pkg::OP_OUT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cmd.op == ffcr_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.op == ffcr_pkg::OP_CAPTURE)
            begin
                side_reg <= 1'b0;
            end
            else if (cmd.op == ffcr_pkg::OP_SIDE)
            begin
                side_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ffcr_pkg::OP_CAPTURE:
            begin
                item_reg <= item;
            end
            ffcr_pkg::OP_READ:
            begin
                flag_reg <= 2'b00;
            end
            ffcr_pkg::OP_MUL_X:
            begin
                dot_reg  <= '0;
                prod_reg <= product;
            end
            ffcr_pkg::OP_MUL_Y, ffcr_pkg::OP_MUL_Z:
            begin
                dot_reg  <= dot_reg + prod_term;
                prod_reg <= product;
            end
            ffcr_pkg::OP_SUM:
            begin
                dot_reg  <= dot_reg + prod_term;
            end
            ffcr_pkg::OP_MUL_F:
            begin
                prod_reg <= product;
                flag_reg <= flag_reg | {dot_sat, 1'b0};
            end
            ffcr_pkg::OP_OUT:
            begin
                result_reg.cell_index <= item_reg.owner_cell;
                if (cell_ok)
                begin
                    result_reg.cell_value <= div_quot;
                    if (rd_flags[ffcr_pkg::FLAG_DIVZ_BIT])
                    begin
                        result_reg.status <= ffcr_pkg::ST_DIVZ;
                    end
                    else if (rd_flags[ffcr_pkg::FLAG_SAT_BIT])
                    begin
                        result_reg.status <= ffcr_pkg::ST_SAT;
                    end
                    else
                    begin
                        result_reg.status <= ffcr_pkg::ST_OK;
                    end
                end
                else
                begin
                    result_reg.cell_value <= '0;
                    result_reg.status     <= ffcr_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.kind     = item_reg.kind;
    assign stat.side     = side_reg;
    assign stat.cell_ok  = cell_ok;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !result_valid_reg || !result_stall;
    assign stat.clr_last = (clr_reg == AW'(CELL_COUNT - 1));

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/ffcr_ctrl.sv
// controller state machine sequencing the datapath
// uses ffcr_pkg
module ffcr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [1:0]      item_kind,
    output logic            item_stall,
    input  ffcr_pkg::stat_t stat,
    output ffcr_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_MX    = 4'd4;
    localparam logic [3:0] S_MY    = 4'd5;
    localparam logic [3:0] S_MZ    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_MF    = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DWAIT = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_RREAD = 4'd13;
    localparam logic [3:0] S_RDIV  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ffcr_pkg::OP_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = ffcr_pkg::OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op = ffcr_pkg::OP_CAPTURE;
                    state_next = S_READ;
                    if (item_kind == ffcr_pkg::KIND_LOAD)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (item_kind == ffcr_pkg::KIND_READOUT)
                    begin
                        state_next = S_RREAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.op = ffcr_pkg::OP_LOAD;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                if (stat.cell_ok)
                begin
                    cmd.op = ffcr_pkg::OP_READ;
                    state_next = S_MX;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_MX:
            begin
                cmd.op = ffcr_pkg::OP_MUL_X;
                state_next = S_MY;
            end
            S_MY:
            begin
                cmd.op = ffcr_pkg::OP_MUL_Y;
                state_next = S_MZ;
            end
            S_MZ:
            begin
                cmd.op = ffcr_pkg::OP_MUL_Z;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op = ffcr_pkg::OP_SUM;
                state_next = S_MF;
            end
            S_MF:
            begin
                cmd.op = ffcr_pkg::OP_MUL_F;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = ffcr_pkg::OP_DIV_FACE;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.op = ffcr_pkg::OP_ACC;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = S_IDLE;
                if (!stat.side && (stat.kind == ffcr_pkg::KIND_INTERIOR))
                begin
                    cmd.op = ffcr_pkg::OP_SIDE;
                    state_next = S_READ;
                end
            end
            S_RREAD:
            begin
                if (stat.cell_ok)
                begin
                    cmd.op = ffcr_pkg::OP_READ;
                    state_next = S_RDIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RDIV:
            begin
                cmd.op = ffcr_pkg::OP_DIV_READ;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // readout: wait for the divider and for a free output slot
                if (!stat.div_busy && stat.out_free)
                begin
                    cmd.op = ffcr_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/face_flux_to_cell_reconstruct.sv
// top level of the face flux to cell reconstruction block
// uses ffcr_pkg, ffcr_ctrl, ffcr_datapath
//
// input channel item / item_valid / item_stall carries one item of four kinds:
// cell load, interior face, boundary face and cell readout. only a readout
// gives a result, on result / result_valid / result_stall.
// one item at a time: item_stall is low only while the controller is idle.
// a load captures the item, then writes the cell stores and returns to idle.
// each face side on a valid cell runs in order: store read, three products
// of the dot product, the sum, the flux product, divider start, the wait
// for the 64 step restoring divider and the accumulator write, then the
// side step; an interior face runs it for both sides, a boundary face once.
// a readout reads the stores, starts the divider, waits for it and for a
// free output slot, then writes the result. a zero divisor skips the 64 divider steps.
// after reset a clearing pass zeroes the accumulator store, one entry a
// cycle over all CELL_COUNT entries, with item_stall high.
// the result sits in an output register; the next item is accepted while it
// waits. a readout that finds the output register still stalled waits
// until it is taken.
module face_flux_to_cell_reconstruct #(
    parameter int CELL_COUNT    = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffcr_pkg::in_item_t  item,
    input  logic                item_valid,
    output logic                item_stall,
    output ffcr_pkg::out_item_t result,
    output logic                result_valid,
    input  logic                result_stall
);

    ffcr_pkg::cmd_t  cmd;
    ffcr_pkg::stat_t stat;

    ffcr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_kind(item.kind),
        .item_stall(item_stall), .stat(stat), .cmd(cmd)
    );

    ffcr_datapath #(.CELL_COUNT(CELL_COUNT), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item), .stat(stat),
        .result(result), .result_valid(result_valid), .result_stall(result_stall)
    );

`ifndef SYNTHESIS
    a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffcr_pkg::OP_CAPTURE) |-> (item_valid && !item_stall))
        else $error("item captured without an accepting handshake");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffcr_pkg::OP_OUT) |-> (!result_valid || !result_stall))
        else $error("result register overwritten while stalled");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ffcr_pkg::OP_DIV_FACE || cmd.op == ffcr_pkg::OP_DIV_READ)
        |-> !stat.div_busy)
        else $error("divider started while busy");
`endif

endmodule
